// ----- design/fmp_pkg.sv -----
// Shared constants and types for the Fibonacci matrix-power block.
// No dependencies; used by fmp_mul and fibonacci_matrix_power.
package fmp_pkg;

	localparam int VALUE_W        = 64;
	localparam int INDEX_W        = 32;
	localparam int DEF_WIDTH      = 64;
	localparam int DEF_INDEX_BITS = 32;

	// Which half-width partial product the multiplier forms.
	typedef enum logic [1:0] {
		PART_LL = 2'd0,
		PART_LH = 2'd1,
		PART_HL = 2'd2
	} part_t;

	typedef struct packed {
		logic  issue;
		logic  to_r0;
		part_t part;
	} mul_ctrl_t;

	typedef struct packed {
		logic valid;
		logic to_r0;
	} mul_res_t;

endpackage

// ----- design/fmp_mul.sv -----
// Shared half-width multiplier forming one partial product of a modular product.
// Depends on fmp_pkg (part_t, mul_ctrl_t, mul_res_t).
module fmp_mul #(
	parameter int WIDTH = fmp_pkg::DEF_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fmp_pkg::mul_ctrl_t   ctrl,
	input  logic [WIDTH-1:0]     op_x,
	input  logic [WIDTH-1:0]     op_y,
	output fmp_pkg::mul_res_t    res,
	output logic [WIDTH-1:0]     prod
);
	import fmp_pkg::*;

	localparam int HALF = (WIDTH + 1) / 2;

	logic [HALF-1:0]   xl, xh, yl, yh, mx, my;
	logic [2*HALF-1:0] full;
	logic [WIDTH-1:0]  shifted;
	logic [WIDTH-1:0]  prod_s1;
	mul_res_t          res_s1;

	assign xl = op_x[HALF-1:0];
	assign yl = op_y[HALF-1:0];
	assign xh = HALF'(op_x[WIDTH-1:HALF]);
	assign yh = HALF'(op_y[WIDTH-1:HALF]);

	always_comb begin
		case (ctrl.part)
			PART_LH: begin
				mx = xl;
				my = yh;
			end
			PART_HL: begin
				mx = xh;
				my = yl;
			end
			default: begin
				mx = xl;
				my = yl;
			end
		endcase
	end

	assign full = mx * my;

	// Cross terms land one half up; bits past WIDTH drop out.
	assign shifted = (ctrl.part == PART_LL) ? WIDTH'(full)
	                                        : WIDTH'({full, {HALF{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else begin
			res_s1.valid <= ctrl.issue;
			res_s1.to_r0 <= ctrl.to_r0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			prod_s1 <= shifted;
		end
	end

	assign res  = res_s1;
	assign prod = prod_s1;

endmodule

// ----- design/fibonacci_matrix_power.sv -----
// Top level: Fibonacci number of an index by fast doubling of Q^k = [[1,1],[1,0]].
// Depends on fmp_pkg and fmp_mul.
//
//   channel | signals                        | direction | payload
//   --------+--------------------------------+-----------+----------------------
//   input   | in_valid, in_ready, index_n    | in        | index_n  [31:0]
//   output  | out_valid, out_ready, fib_value| out       | fib_value[63:0]
//
// Per index bit, MSB first, the sequencer runs a prep state, nine half-width
// multiplier passes, a drain and an update state; after the last bit a done state
// loads the output register once it has room. Reset clears sequencer and out_valid.
// in_ready is high only in idle, even while a result waits; a stalled out_ready
// stalls the sequencer only once the next result is done.
module fibonacci_matrix_power #(
	parameter int WIDTH      = fmp_pkg::DEF_WIDTH,
	parameter int INDEX_BITS = fmp_pkg::DEF_INDEX_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [fmp_pkg::INDEX_W-1:0]  index_n,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [fmp_pkg::VALUE_W-1:0]  fib_value
);
	import fmp_pkg::*;

	localparam int CNT_W = $clog2(INDEX_BITS);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_PREP   = 6'b000010,
		S_MUL    = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_UPDATE = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	// Which of the three doubling products is on the multiplier.
	typedef enum logic [1:0] {
		PROD_AT = 2'd0,   // F(k) * (2F(k+1) - F(k))  -> F(2k)
		PROD_BB = 2'd1,   // F(k+1)^2                 -> part of F(2k+1)
		PROD_AA = 2'd2    // F(k)^2                   -> part of F(2k+1)
	} prod_t;

	state_t            state_q;
	prod_t             prod_sel_q;
	part_t             part_q;
	logic [CNT_W-1:0]  bit_cnt_q;
	logic [INDEX_BITS-1:0] n_q;
	logic [WIDTH-1:0]  a_q, b_q, t_q, r0_q, r1_q;
	logic [WIDTH-1:0]  fib_q;
	logic              out_valid_q;

	mul_ctrl_t         mctrl;
	mul_res_t          mres;
	logic [WIDTH-1:0]  op_x, op_y, mprod;
	logic              out_free;
	logic              last_pass;

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign last_pass = (prod_sel_q == PROD_AA) && (part_q == PART_HL);

	// Operand routing for the shared multiplier.
	always_comb begin
		case (prod_sel_q)
			PROD_AT: begin
				op_x = a_q;
				op_y = t_q;
			end
			PROD_BB: begin
				op_x = b_q;
				op_y = b_q;
			end
			default: begin
				op_x = a_q;
				op_y = a_q;
			end
		endcase
	end

	assign mctrl.issue = (state_q == S_MUL);
	assign mctrl.to_r0 = (prod_sel_q == PROD_AT);
	assign mctrl.part  = part_q;

	fmp_mul #(
		.WIDTH(WIDTH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mctrl),
		.op_x   (op_x),
		.op_y   (op_y),
		.res    (mres),
		.prod   (mprod)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prod_sel_q  <= PROD_AT;
			part_q      <= PART_LL;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						bit_cnt_q <= CNT_W'(INDEX_BITS - 1);
						state_q   <= S_PREP;
					end
				end
				S_PREP: begin
					prod_sel_q <= PROD_AT;
					part_q     <= PART_LL;
					state_q    <= S_MUL;
				end
				S_MUL: begin
					// Advance through LL, LH, HL of each product in turn.
					unique case (part_q)
						PART_LL: part_q <= PART_LH;
						PART_LH: part_q <= PART_HL;
						default: begin
							part_q <= PART_LL;
							unique case (prod_sel_q)
								PROD_AT: prod_sel_q <= PROD_BB;
								PROD_BB: prod_sel_q <= PROD_AA;
								default: prod_sel_q <= PROD_AT;
							endcase
						end
					endcase
					if (last_pass) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (bit_cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						bit_cnt_q <= bit_cnt_q - 1'b1;
						state_q   <= S_PREP;
					end
				end
				S_DONE: begin
					// Hold here until the output register has room.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: F(k) in a_q, F(k+1) in b_q.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			n_q <= index_n[INDEX_BITS-1:0];
			a_q <= '0;
			b_q <= WIDTH'(1);
		end

		if (state_q == S_PREP) begin
			t_q  <= (b_q << 1) - a_q;
			r0_q <= '0;
			r1_q <= '0;
		end else if (mres.valid) begin
			// Accumulate partials: F(2k) in r0, F(k+1)^2 + F(k)^2 in r1.
			if (mres.to_r0) begin
				r0_q <= r0_q + mprod;
			end else begin
				r1_q <= r1_q + mprod;
			end
		end

		if (state_q == S_UPDATE) begin
			// A set bit steps k by one more: (F(2k+1), F(2k) + F(2k+1)).
			if (n_q[INDEX_BITS-1]) begin
				a_q <= r1_q;
				b_q <= r0_q + r1_q;
			end else begin
				a_q <= r0_q;
				b_q <= r1_q;
			end
			n_q <= n_q << 1;
		end

		if ((state_q == S_DONE) && out_free) begin
			fib_q <= a_q;
		end
	end

	assign out_valid = out_valid_q;
	assign fib_value = VALUE_W'(fib_q);

endmodule

// ----- design/fmp_check.sv -----
// Port-level checks for fibonacci_matrix_power, attached by bind.
// No package dependency; sees the top level's ports only.
module fmp_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] index_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] fib_value
);

	// The sequencer is busy right after taking a word.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after a word was accepted");

	// No fresh result can rise while a new word is in its prep state and first multiplier pass.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!$rose(out_valid) ##1 !$rose(out_valid)))
		else $error("result appeared too soon after acceptance");

	// Returning to idle always coincides with a loaded output register.
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("sequencer went idle without presenting a result");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(fib_value)))
		else $error("stalled result word changed or dropped");

endmodule

bind fibonacci_matrix_power fmp_check u_fmp_check (.*);

// ----- tb/testbench.sv -----
// Self-checking bench for fibonacci_matrix_power: drives indices over valid/ready
// and checks each returned Fibonacci word against a matrix-power predictor.
// Depends on fmp_pkg and the fibonacci_matrix_power RTL only.
module testbench;

	import fmp_pkg::*;

	// Build the block at its defaults and predict at the same widths.
	localparam int FIB_W    = DEF_WIDTH;
	localparam int IDX_BITS = DEF_INDEX_BITS;
	localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - FIB_W);
	localparam logic [INDEX_W-1:0] INDEX_MASK = {INDEX_W{1'b1}} >> (INDEX_W - IDX_BITS);

	// Time for one word, and a drain wait with some slack on top.
	localparam int WORD_LATENCY    = 12 * IDX_BITS + 2;
	localparam int DRAIN_CYCLES    = WORD_LATENCY + 50;
	localparam int HOLD_OFF_CYCLES = 5 * WORD_LATENCY;
	localparam int RANDOM_PER_PHASE = 600;

	// 2x2 matrix over Z / 2^FIB_W.
	typedef struct {
		logic [VALUE_W-1:0] e00, e01, e10, e11;
	} fib_mat_t;

	// Plain 2x2 product with every entry wrapped to FIB_W bits.
	function automatic fib_mat_t mat_product(fib_mat_t a, fib_mat_t b);
		fib_mat_t c;
		c.e00 = (a.e00 * b.e00 + a.e01 * b.e10) & VALUE_MASK;
		c.e01 = (a.e00 * b.e01 + a.e01 * b.e11) & VALUE_MASK;
		c.e10 = (a.e10 * b.e00 + a.e11 * b.e10) & VALUE_MASK;
		c.e11 = (a.e10 * b.e01 + a.e11 * b.e11) & VALUE_MASK;
		return c;
	endfunction

	// F(n) mod 2^FIB_W: raise Q = [[1,1],[1,0]] to n, MSB first, take the
	// off-diagonal entry. Index bits at and above IDX_BITS are dropped.
	function automatic logic [VALUE_W-1:0] fib_mod(logic [INDEX_W-1:0] index);
		fib_mat_t           acc;
		fib_mat_t           q;
		logic [INDEX_W-1:0] n;
		n   = index & INDEX_MASK;
		acc = '{e00: 1, e01: 0, e10: 0, e11: 1};
		q   = '{e00: 1, e01: 1, e10: 1, e11: 0};
		for (int b = IDX_BITS - 1; b >= 0; b--) begin
			acc = mat_product(acc, acc);
			if (n[b])
				acc = mat_product(acc, q);
		end
		return acc.e01 & VALUE_MASK;
	endfunction

	// Holds the Fibonacci words still owed by the block, oldest first.
	class fib_scoreboard;
		logic [VALUE_W-1:0] owed_values[$];
		int                 errors;

		function new();
			errors = 0;
		endfunction

		// Note an index the block has taken; queue its Fibonacci word.
		function void note_index(logic [INDEX_W-1:0] index);
			owed_values.push_back(fib_mod(index));
		endfunction

		// Compare a returned word with the oldest one owed.
		function void check_value(logic [VALUE_W-1:0] actual);
			logic [VALUE_W-1:0] owed;
			if (owed_values.size() == 0) begin
				$error("fib_value: unexpected word %0h with nothing outstanding", actual);
				errors++;
			end else begin
				owed = owed_values.pop_front();
				if (actual !== owed) begin
					$error("fib_value mismatch: expected %0h actual %0h", owed, actual);
					errors++;
				end
			end
		endfunction
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [INDEX_W-1:0] index_n   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VALUE_W-1:0] fib_value;

	// Idle rates in percent per cycle, changed between phases by the main process.
	int  send_idle_pct = 33;
	int  recv_idle_pct = 45;
	// Raised once to make the receiver hold off long enough to back up the input.
	bit  hold_off_request = 1'b0;

	fib_scoreboard fib_sb = new();

	fibonacci_matrix_power #(
		.WIDTH      (FIB_W),
		.INDEX_BITS (IDX_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.index_n   (index_n),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.fib_value (fib_value)
	);

	always #4 clk = ~clk;

	// Watchdog: ends the run with a failure if it has not finished.
	initial begin
		#(8 * 4_000_000);
		$display("tb: failure");
		$finish;
	end

	// Receiver: toggle out_ready on the falling edge. On request, drop ready
	// for a long stretch so a finished word sits in the output register, the
	// sequencer finishes the next one and in_ready stays low.
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Monitor: sample the result channel on the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			fib_sb.check_value(fib_value);
	end

	// Offer one index. Call at a falling edge; returns at the falling edge
	// after the word is taken, with in_valid still high so a back-to-back
	// word needs no drop of valid in between.
	task automatic send_index(input logic [INDEX_W-1:0] index);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		index_n  <= index;
		do
			@(posedge clk);
		while (!in_ready);
		fib_sb.note_index(index);
		@(negedge clk);
	endtask

	// Mix small indices, up to just past where F(n) first wraps, with
	// mid-range and full-width ones so every index bit toggles.
	function automatic logic [INDEX_W-1:0] random_index();
		case ($urandom_range(3))
			0:       return $urandom_range(120);
			1:       return $urandom_range(65535);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_index(random_index());
	endtask

	initial begin : stimulus
		logic [INDEX_W-1:0] directed[$];

		// Hold reset, then release it on a falling edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: index zero, the first few terms, the last term that fits
		// 64 bits and the first that wraps, and bit patterns at the extremes.
		directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd10, 32'd47, 32'd48,
			32'd93, 32'd94, 32'd95, 32'd1000, 32'h0000_FFFF, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
			32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0};
		foreach (directed[i])
			send_index(directed[i]);

		// Receiver idles more than the sender, then the reverse.
		send_random(RANDOM_PER_PHASE);
		send_idle_pct = 45;
		recv_idle_pct = 33;
		send_random(RANDOM_PER_PHASE);

		// No idling; start with a long receiver hold-off so the input stalls.
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		hold_off_request = 1'b1;
		send_random(RANDOM_PER_PHASE);
		in_valid <= 1'b0;

		// Drain: wait for every owed word, then DRAIN_CYCLES more to
		// catch any stray result.
		while (fib_sb.owed_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fib_sb.owed_values.size() != 0) begin
			$error("fib_value: %0d words never returned", fib_sb.owed_values.size());
			fib_sb.errors++;
		end

		if (fib_sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
